// ===== design/cat_pkg.sv =====
`default_nettype none

package cat_pkg;

    // Number of pending-segment cells in the row
    localparam int PENDING_SLOTS = 16;

    localparam int SEQ_W = 32;
    localparam int LEN_W = 16;

    // Command codes broadcast to every cell
    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_WALK   = 2'd2;

    // Command broadcast from the sequencer to all cells
    typedef struct packed {
        logic [1:0]       op;
        logic [SEQ_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic             no_dup;
    } cmd_t;

    // Data handed from one cell to its right-hand neighbor
    typedef struct packed {
        logic             any_hit;
        logic             all_busy;
        logic [LEN_W-1:0] hit_len;
    } chain_t;

endpackage

`default_nettype wire

// ===== design/cat_cell.sv =====
`default_nettype none

module cat_cell
    import cat_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cmd_t cmd,
    input  wire chain_t chain_in,
    output chain_t    chain_out
);

    logic             valid_reg;
    logic             valid_next;
    logic [SEQ_W-1:0] start_reg;
    logic [SEQ_W-1:0] start_next;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic             hit;
    logic             claim;

    // Compare the stored start against the broadcast key
    assign hit   = valid_reg && (start_reg == cmd.key);
    // First free cell from the left claims a new segment
    assign claim = !valid_reg && chain_in.all_busy;

    // Pass match and free-slot status on to the neighbor
    always_comb begin
        chain_out.any_hit  = chain_in.any_hit | hit;
        chain_out.all_busy = chain_in.all_busy & valid_reg;
        chain_out.hit_len  = chain_in.hit_len | (hit ? length_reg : {LEN_W{1'b0}});
    end

    // Insert overwrites a duplicate or fills the claimed cell; walk frees a hit
    always_comb begin
        valid_next  = valid_reg;
        start_next  = start_reg;
        length_next = length_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (hit) begin
                    length_next = cmd.len;
                end else if (claim && cmd.no_dup) begin
                    valid_next  = 1'b1;
                    start_next  = cmd.key;
                    length_next = cmd.len;
                end
            end
            OP_WALK: begin
                if (hit) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg  <= start_next;
        length_reg <= length_next;
    end

endmodule

`default_nettype wire

// ===== design/cat_row.sv =====
`default_nettype none

module cat_row
    import cat_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cmd_t cmd,
    output chain_t    row_status
);

    chain_t chain [0:PENDING_SLOTS];

    // Seed the left end: no hit yet, every cell so far busy
    always_comb begin
        chain[0].any_hit  = 1'b0;
        chain[0].all_busy = 1'b1;
        chain[0].hit_len  = {LEN_W{1'b0}};
    end

    genvar g;
    generate
        for (g = 0; g < PENDING_SLOTS; g++) begin : g_cell
            cat_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .chain_in  (chain[g]),
                .chain_out (chain[g+1])
            );
        end
    endgenerate

    assign row_status = chain[PENDING_SLOTS];

endmodule

`default_nettype wire

// ===== design/cumulative_ack_tracker.sv =====
`default_nettype none

// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   action, seq_num, ack_num, payload_len
// m_        out        m_valid / m_ready   result_kind, ack_value, not_recorded
//
// An ack word goes from idle through the done state to the output register; a data word
// goes through insert, walk and done (insert skipped at zero length), the walk consuming
// 0..PENDING_SLOTS pending segments, one per cycle through the broadcast compare in the row.
// Reset (aresetn low, synchronous) frees all cells and clears the expected number.
// One word is in work at a time; s_ready is low until its result is in the
// output register, which may still hold an untaken result meanwhile.

module cumulative_ack_tracker
    import cat_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_action,
    input  wire logic [SEQ_W-1:0] s_seq_num,
    input  wire logic [SEQ_W-1:0] s_ack_num,
    input  wire logic [LEN_W-1:0] s_payload_len,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_result_kind,
    output logic [SEQ_W-1:0]      m_ack_value,
    output logic                  m_not_recorded
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             kind_reg;
    logic             kind_next;
    logic [SEQ_W-1:0] key_reg;
    logic [SEQ_W-1:0] key_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             drop_reg;
    logic             drop_next;
    logic [SEQ_W-1:0] expected_reg;
    logic [SEQ_W-1:0] expected_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             m_kind_reg;
    logic             m_kind_next;
    logic [SEQ_W-1:0] m_value_reg;
    logic [SEQ_W-1:0] m_value_next;
    logic             m_drop_reg;
    logic             m_drop_next;
    cmd_t             cmd;
    chain_t           row_status;
    logic             out_free;

    cat_row u_row (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .row_status (row_status)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_ack_value    = m_value_reg;
    assign m_not_recorded = m_drop_reg;
    assign out_free       = !m_valid_reg || m_ready;

    // Drive the cell row: insert the word's segment, then walk on the expected number
    always_comb begin
        cmd.op     = OP_NOP;
        cmd.key    = key_reg;
        cmd.len    = len_reg;
        cmd.no_dup = !row_status.any_hit;
        case (state_reg)
            ST_INSERT: cmd.op = OP_INSERT;
            ST_WALK: begin
                cmd.op  = OP_WALK;
                cmd.key = expected_reg;
            end
            default: cmd.op = OP_NOP;
        endcase
    end

    // Sequence one word and load the output register when it is free
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        len_next      = len_reg;
        drop_next     = drop_reg;
        expected_next = expected_reg;
        m_valid_next  = m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_value_next  = m_value_reg;
        m_drop_next   = m_drop_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_action;
                    key_next  = s_action ? s_ack_num : s_seq_num;
                    len_next  = s_payload_len;
                    drop_next = 1'b0;
                    if (s_action) begin
                        state_next = ST_DONE;
                    end else if (s_payload_len != {LEN_W{1'b0}}) begin
                        state_next = ST_INSERT;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_INSERT: begin
                drop_next  = !row_status.any_hit && row_status.all_busy;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (row_status.any_hit) begin
                    expected_next = expected_reg + {{(SEQ_W-LEN_W){1'b0}}, row_status.hit_len};
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    m_value_next = kind_reg ? key_reg : expected_reg;
                    m_drop_next  = kind_reg ? 1'b0 : drop_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            expected_reg <= {SEQ_W{1'b0}};
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            expected_reg <= expected_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        len_reg     <= len_next;
        drop_reg    <= drop_next;
        m_kind_reg  <= m_kind_next;
        m_value_reg <= m_value_next;
        m_drop_reg  <= m_drop_next;
    end

`ifndef ASSERT_OFF
    // A new result word appears only after the done state
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> (state_reg == ST_DONE))
        else $error("result loaded outside done state");

    // Each walk hit advances the expected number by the hit length
    a_walk_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && row_status.any_hit) |=>
        (expected_reg == $past(expected_reg)
            + {{(SEQ_W-LEN_W){1'b0}}, $past(row_status.hit_len)}))
        else $error("expected number did not advance by hit length");

    // Zero-length segments and ack words never reach the insert step
    a_insert_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSERT) |-> (len_reg != {LEN_W{1'b0}} && !kind_reg))
        else $error("insert of zero-length or ack word");

    // A forwarded ack never carries the drop flag
    a_ack_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg) |-> !m_drop_reg)
        else $error("forwarded ack flagged as dropped");
`endif

endmodule

`default_nettype wire
